// File: rtl/hnft_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the HDLC NRZI frame transmitter.
// Used by hnft_byte_enc and hdlc_nrzi_frame_transmitter_core; no dependencies.
package hnft_pkg;

	localparam logic [15:0] CRC_POLY   = 16'h8408;
	localparam logic [15:0] CRC_PRESET = 16'hFFFF;
	localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
	localparam logic [2:0]  STUFF_RUN  = 3'd5;

	typedef enum logic [1:0] {
		FUNC_START = 2'd0,
		FUNC_FLAG  = 2'd1,
		FUNC_DATA  = 2'd2,
		FUNC_END   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		PH_LOW,
		PH_HIGH,
		PH_FLAG
	} fcs_phase_t;

	typedef struct packed {
		logic        level;
		logic [15:0] crc;
		logic [2:0]  run;
	} line_state_t;

	typedef struct packed {
		logic raw;
		logic crc_on;
	} enc_ctl_t;

endpackage

// File: rtl/hnft_byte_enc.sv
`timescale 1ns / 1ps
// Combinational byte encoder: CRC update, bit stuffing and NRZI coding of one byte.
// Depends on hnft_pkg.
module hnft_byte_enc
	import hnft_pkg::*;
(
	input  logic [7:0]  value,
	input  enc_ctl_t    ctl,
	input  line_state_t st_in,
	output line_state_t st_out,
	output logic [9:0]  bits,
	output logic [3:0]  count
);

	logic        lvl;
	logic [15:0] crc;
	logic [2:0]  run;
	logic [3:0]  pos;
	logic [9:0]  acc;
	logic        b;
	logic        fb;

	always_comb begin
		lvl = st_in.level;
		crc = st_in.crc;
		run = st_in.run;
		pos = '0;
		acc = '0;
		b   = 1'b0;
		fb  = 1'b0;
		for (int k = 0; k < 8; k++) begin
			b = value[k];
			if (ctl.crc_on) begin
				fb  = crc[0] ^ b;
				crc = {1'b0, crc[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
			end
			if (!b) begin
				run = '0;
				lvl = ~lvl;
			end else if (!ctl.raw) begin
				run = run + 3'd1;
				if (run == STUFF_RUN) begin
					acc[pos] = lvl;
					pos      = pos + 4'd1;
					run      = '0;
					lvl      = ~lvl;
				end
			end
			acc[pos] = lvl;
			pos      = pos + 4'd1;
		end
		st_out.level = lvl;
		st_out.crc   = crc;
		st_out.run   = run;
		bits         = acc;
		count        = pos;
	end

endmodule

// File: rtl/hdlc_nrzi_frame_transmitter_core.sv
`timescale 1ns / 1ps
// Top level of the HDLC NRZI frame transmitter: request register, FCS sequencer
// and result register. Depends on hnft_pkg and hnft_byte_enc.
//
// Requests arrive on the in_valid/in_ready channel with func and byte_value.
// A start request resets the line level, CRC and stuffing run and gives no
// result. A flag or data request gives one result; an end request gives three
// (CRC low byte, CRC high byte, closing flag), with last set on the final one.
// Each result carries up to ten NRZI line levels and their count on the
// out_valid/out_ready channel.
// The first result of a request passes through the request register and then
// the result register. One request is taken per cycle while results drain; an
// end request holds the request register until its three results are loaded,
// as the single byte encoder produces one byte of line levels per cycle.
// A stalled receiver holds the result register and back-pressures the input
// through in_ready. Reset empties both registers, sets the level low, the CRC
// to all ones and the run count to zero.
module hdlc_nrzi_frame_transmitter_core
	import hnft_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  logic [7:0] byte_value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [9:0] line_bits,
	output logic [3:0] bit_count,
	output logic       last
);

	logic        valid_s1;
	func_t       func_s1;
	logic [7:0]  byte_s1;
	fcs_phase_t  phase_q;
	fcs_phase_t  phase_d;
	line_state_t st_q;
	line_state_t enc_st_in;
	line_state_t enc_st_out;
	enc_ctl_t    enc_ctl;
	logic [7:0]  enc_value;
	logic [9:0]  enc_bits;
	logic [3:0]  enc_count;
	logic        enc_last;
	logic        out_load;
	logic        done_s1;
	logic        out_valid_q;
	logic [9:0]  line_bits_q;
	logic [3:0]  bit_count_q;
	logic        last_q;

	assign out_load = valid_s1 && (func_s1 != FUNC_START) && (!out_valid_q || out_ready);
	assign enc_last = (func_s1 != FUNC_END) || (phase_q == PH_FLAG);
	assign done_s1  = valid_s1 && ((func_s1 == FUNC_START) || (out_load && enc_last));
	assign in_ready = !valid_s1 || done_s1;

	always_comb begin
		enc_st_in = st_q;
		enc_value = byte_s1;
		enc_ctl   = '{raw: 1'b0, crc_on: 1'b0};
		unique case (func_s1)
			FUNC_START: begin
			end
			FUNC_FLAG: begin
				enc_ctl.raw = 1'b1;
			end
			FUNC_DATA: begin
				enc_ctl.crc_on = 1'b1;
			end
			FUNC_END: begin
				unique case (phase_q)
					PH_LOW: begin
						enc_st_in.crc = ~st_q.crc;
						enc_value     = ~st_q.crc[7:0];
					end
					PH_HIGH: begin
						enc_value = st_q.crc[15:8];
					end
					PH_FLAG: begin
						enc_value   = FLAG_BYTE;
						enc_ctl.raw = 1'b1;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	hnft_byte_enc u_enc (
		.value  (enc_value),
		.ctl    (enc_ctl),
		.st_in  (enc_st_in),
		.st_out (enc_st_out),
		.bits   (enc_bits),
		.count  (enc_count)
	);

	always_comb begin
		phase_d = phase_q;
		if (out_load && (func_s1 == FUNC_END)) begin
			unique case (phase_q)
				PH_LOW:  phase_d = PH_HIGH;
				PH_HIGH: phase_d = PH_FLAG;
				PH_FLAG: phase_d = PH_LOW;
				default: phase_d = PH_LOW;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LOW;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1 <= func_t'(func);
			byte_s1 <= byte_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{level: 1'b0, crc: CRC_PRESET, run: 3'd0};
		end else if (valid_s1 && (func_s1 == FUNC_START)) begin
			st_q <= '{level: 1'b0, crc: CRC_PRESET, run: 3'd0};
		end else if (out_load) begin
			st_q <= enc_st_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			line_bits_q <= enc_bits;
			bit_count_q <= enc_count;
			last_q      <= enc_last;
		end
	end

	assign out_valid = out_valid_q;
	assign line_bits = line_bits_q;
	assign bit_count = bit_count_q;
	assign last      = last_q;

endmodule

// File: verif/hdlc_nrzi_frame_transmitter_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for hdlc_nrzi_frame_transmitter_core: a directed table of requests,
// then random frames and lone requests under varied idling, against a line-coding predictor.
// Depends on hnft_pkg and the transmitter RTL.
module hdlc_nrzi_frame_transmitter_core_tb;
	import hnft_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_REQUESTS = 55;
	localparam int NUM_PHASES = 4;
	localparam int NUM_DIRECTED = 24;
	localparam int TAIL_CYCLES = 8;

	typedef struct packed {
		logic [9:0] levels;
		logic [3:0] count;
		logic       fin;
	} line_word_t;

	typedef struct packed {
		func_t      code;
		logic [7:0] value;
		logic       typed;
		line_word_t want;
	} step_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] func = FUNC_START;
	logic [7:0] byte_value = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [9:0] line_bits;
	logic [3:0] bit_count;
	logic       last;

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int fail_count = 0;
	int cycle_count = 0;

	logic        pred_level = 1'b0;
	logic [15:0] pred_fcs = CRC_PRESET;
	logic [2:0]  pred_run = 3'd0;
	line_word_t  expected_words [$];

	int sender_idle_sched [NUM_PHASES] = '{0, 86, 0, 27};
	int receiver_stall_sched [NUM_PHASES] = '{0, 0, 86, 27};

	step_row_t directed_steps [NUM_DIRECTED] = '{
		'{FUNC_FLAG,  8'h7E, 1'b1, '{10'h07F, 4'd8, 1'b1}},
		'{FUNC_DATA,  8'hFF, 1'b1, '{10'h1E0, 4'd9, 1'b1}},
		'{FUNC_START, 8'h00, 1'b0, '0},
		'{FUNC_END,   8'h00, 1'b0, '0},
		'{FUNC_START, 8'hFF, 1'b0, '0},
		'{FUNC_DATA,  8'h00, 1'b0, '0},
		'{FUNC_DATA,  8'hF0, 1'b0, '0},
		'{FUNC_DATA,  8'hFF, 1'b0, '0},
		'{FUNC_FLAG,  8'hFF, 1'b0, '0},
		'{FUNC_FLAG,  8'h00, 1'b0, '0},
		'{FUNC_DATA,  8'h7E, 1'b0, '0},
		'{FUNC_DATA,  8'h01, 1'b0, '0},
		'{FUNC_DATA,  8'h80, 1'b0, '0},
		'{FUNC_DATA,  8'h55, 1'b0, '0},
		'{FUNC_DATA,  8'hAA, 1'b0, '0},
		'{FUNC_END,   8'hA5, 1'b0, '0},
		'{FUNC_END,   8'h00, 1'b0, '0},
		'{FUNC_FLAG,  8'h7E, 1'b0, '0},
		'{FUNC_START, 8'h00, 1'b0, '0},
		'{FUNC_DATA,  8'h0F, 1'b0, '0},
		'{FUNC_DATA,  8'hF0, 1'b0, '0},
		'{FUNC_FLAG,  8'hFF, 1'b0, '0},
		'{FUNC_DATA,  8'h01, 1'b0, '0},
		'{FUNC_END,   8'h3C, 1'b0, '0}
	};

	hdlc_nrzi_frame_transmitter_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.byte_value (byte_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.line_bits  (line_bits),
		.bit_count  (bit_count),
		.last       (last)
	);

	always #5 clk = ~clk;

	function automatic line_word_t encode_line_byte(input logic [7:0] value, input logic raw,
			input logic fcs_on, input logic is_last);
		line_word_t word;
		int n;
		logic b;
		logic fb;
		word = '0;
		n = 0;
		for (int k = 0; k < 8; k++) begin
			b = value[k];
			if (fcs_on) begin
				fb = pred_fcs[0] ^ b;
				pred_fcs = pred_fcs >> 1;
				if (fb)
					pred_fcs = pred_fcs ^ CRC_POLY;
			end
			if (!b) begin
				pred_run = 3'd0;
				pred_level = ~pred_level;
			end else if (!raw) begin
				pred_run = pred_run + 3'd1;
				if (pred_run == STUFF_RUN) begin
					word.levels[n] = pred_level;
					n++;
					pred_run = 3'd0;
					pred_level = ~pred_level;
				end
			end
			word.levels[n] = pred_level;
			n++;
		end
		word.count = 4'(n);
		word.fin = is_last;
		return word;
	endfunction

	task automatic predict_line_words(input func_t code, input logic [7:0] value);
		logic [15:0] fcs;
		case (code)
			FUNC_START: begin
				pred_level = 1'b0;
				pred_fcs = CRC_PRESET;
				pred_run = 3'd0;
			end
			FUNC_FLAG: expected_words.push_back(encode_line_byte(value, 1'b1, 1'b0, 1'b1));
			FUNC_DATA: expected_words.push_back(encode_line_byte(value, 1'b0, 1'b1, 1'b1));
			default: begin
				pred_fcs = ~pred_fcs;
				fcs = pred_fcs;
				expected_words.push_back(encode_line_byte(fcs[7:0], 1'b0, 1'b0, 1'b0));
				expected_words.push_back(encode_line_byte(fcs[15:8], 1'b0, 1'b0, 1'b0));
				expected_words.push_back(encode_line_byte(FLAG_BYTE, 1'b1, 1'b0, 1'b1));
			end
		endcase
	endtask

	task automatic send_request(input func_t code, input logic [7:0] value);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= code;
		byte_value <= value;
		do
			@(posedge clk);
		while (!in_ready);
		predict_line_words(code, value);
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (expected_words.size() != 0);
	endtask

	task automatic check_field(input string tag, input int want, input int got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, tag, want, got);
		end
	endtask

	function automatic logic [7:0] random_byte();
		return ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom);
	endfunction

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= receiver_stall_pct);

	always @(posedge clk) begin
		line_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result, expected none, actual %h/%0d/%0b",
					$time, line_bits, bit_count, last);
			end else begin
				want = expected_words.pop_front();
				check_field("line_bits", int'(want.levels), int'(line_bits));
				check_field("bit_count", int'(want.count), int'(bit_count));
				check_field("last", int'(want.fin), int'(last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int sent;
		int n_flags;
		int n_data;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[i]) begin
			send_request(directed_steps[i].code, directed_steps[i].value);
			if (directed_steps[i].typed)
				expected_words[expected_words.size() - 1] = directed_steps[i].want;
		end
		in_valid <= 1'b0;
		wait_drained();

		for (int p = 0; p < NUM_PHASES; p++) begin
			sender_idle_pct = sender_idle_sched[p];
			receiver_stall_pct = receiver_stall_sched[p];
			sent = 0;
			while (sent < PHASE_REQUESTS) begin
				if ($urandom_range(4) != 0) begin
					n_flags = $urandom_range(2, 1);
					n_data = $urandom_range(6, 1);
					send_request(FUNC_START, 8'($urandom));
					repeat (n_flags) send_request(FUNC_FLAG, FLAG_BYTE);
					repeat (n_data) send_request(FUNC_DATA, random_byte());
					send_request(FUNC_END, 8'($urandom));
					sent += n_flags + n_data + 2;
				end else begin
					send_request(func_t'($urandom_range(3)), random_byte());
					sent++;
				end
			end
			in_valid <= 1'b0;
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
